// ===== hdl/mfh_pkg.sv =====
// ----------------------------------------------------------------------------
// mfh_pkg
// Shared constants, command codes and controller/datapath bundles for the
// Mertens function engine.
// ----------------------------------------------------------------------------
package mfh_pkg;

  localparam int MAX_ROOT  = 2048;
  localparam int ROOT_W    = $clog2(MAX_ROOT + 1);
  localparam int X_W       = 23;
  localparam int VAL_W     = 13;
  localparam int TOT_W     = 32;
  localparam int TAB_DEPTH = 2 * MAX_ROOT;
  localparam int ADDR_W    = $clog2(TAB_DEPTH);
  localparam int CNT_W     = ADDR_W + 1;
  localparam int BIT_W     = $clog2(ROOT_W);
  localparam int SQ_W      = 2 * ROOT_W;
  localparam int DCNT_W    = $clog2(X_W + 1);
  localparam int PROD_W    = X_W + 1 + VAL_W;

  localparam logic [SQ_W-1:0] LIMIT = SQ_W'(MAX_ROOT * MAX_ROOT);
  localparam logic signed [TOT_W-1:0] OUT_MAX = TOT_W'((1 << (VAL_W - 1)) - 1);
  localparam logic signed [TOT_W-1:0] OUT_MIN = -TOT_W'(1 << (VAL_W - 1));

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQRT,
    OP_DIV_XS,
    OP_SETUP,
    OP_EVSTART,
    OP_DIV_VK,
    OP_QCAP,
    OP_DIV_VQ,
    OP_NKCAP,
    OP_RD_SMALL,
    OP_DIV_XQ,
    OP_RD_LARGE,
    OP_MUL,
    OP_ACC,
    OP_WR_SMALL,
    OP_DIV_XV,
    OP_WR_LARGE,
    OP_VINC,
    OP_PHB,
    OP_IDEC,
    OP_DIV_XI,
    OP_BCAP,
    OP_FINISH
  } mfh_op_e;

  typedef struct packed {
    mfh_op_e op;
  } mfh_cmd_t;

  typedef struct packed {
    logic over;
    logic zero;
    logic sqrt_last;
    logic div_done;
    logic k_le_v;
    logic q_le_s;
    logic v_le_s;
    logic v_lt_s;
    logic phase_b;
    logic i_one;
    logic out_free;
  } mfh_stat_t;

endpackage

// ===== hdl/mfh_ram.sv =====
// ----------------------------------------------------------------------------
// mfh_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mfh_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/mfh_div.sv =====
// ----------------------------------------------------------------------------
// mfh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfh_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [mfh_pkg::X_W-1:0] dividend_i,
  input  logic [mfh_pkg::X_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [mfh_pkg::X_W-1:0] quot_o
);
  import mfh_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [X_W-1:0]    rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [X_W:0]      rem_w;
  logic              ge;

  assign rem_w = {rem_q, quo_q[X_W-1]};
  assign ge    = rem_w >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DCNT_W'(X_W);
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? X_W'(rem_w - {1'b0, dvs_q}) : rem_w[X_W-1:0];
      quo_d = {quo_q[X_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == DCNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// ===== hdl/mfh_dp.sv =====
// ----------------------------------------------------------------------------
// mfh_dp
// Datapath: bound and root registers, value walk counters, shared divider,
// multiply-accumulate, partial result table and output register.
// ----------------------------------------------------------------------------
module mfh_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  mfh_pkg::mfh_cmd_t            cmd_i,
  output mfh_pkg::mfh_stat_t           stat_o,
  input  logic [mfh_pkg::X_W-1:0]      bound_x_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [mfh_pkg::VAL_W-1:0] mertens_value_o,
  output logic                         range_error_o
);
  import mfh_pkg::*;

  logic [X_W-1:0]    x_q, x_d, v_q, v_d, k_q, k_d, q_q, q_d, nk_q, nk_d;
  logic [ROOT_W-1:0] root_q, root_d, i_q, i_d, trial;
  logic [BIT_W-1:0]  bit_q, bit_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic signed [TOT_W-1:0] total_q, total_d, prod_q, prod_d;
  logic              phb_q, phb_d;
  logic [SQ_W-1:0]   sq;
  logic signed [PROD_W-1:0] prod_w;

  logic              div_start, div_done;
  logic [X_W-1:0]    div_a, div_b, quot;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [VAL_W-1:0]  ram_rdata;

  logic              ov_q, ov_d, err_q, err_d;
  logic signed [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0]  large_addr;

  mfh_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_a),
    .divisor_i  (div_b),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  mfh_ram #(
    .Width (VAL_W),
    .Depth (TAB_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (ram_addr),
    .wdata_i (total_q[VAL_W-1:0]),
    .rdata_o (ram_rdata)
  );

  assign trial      = root_q | (ROOT_W'(1) << bit_q);
  assign sq         = SQ_W'(trial) * SQ_W'(trial);
  assign large_addr = cnt_q - CNT_W'(quot);
  assign prod_w     = $signed({1'b0, X_W'(nk_q - k_q)}) * $signed(ram_rdata);

  always_comb begin
    x_d = x_q; v_d = v_q; k_d = k_q; q_d = q_q; nk_d = nk_q;
    root_d = root_q; i_d = i_q; bit_d = bit_q; cnt_d = cnt_q;
    total_d = total_q; prod_d = prod_q; phb_d = phb_q;
    ov_d = ov_q; err_d = err_q; val_d = val_q;
    div_start = 1'b0; div_a = x_q; div_b = X_W'(root_q);
    ram_we = 1'b0; ram_re = 1'b0; ram_addr = '0;
    if (out_ready_i) begin
      ov_d = 1'b0;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        x_d = bound_x_i; root_d = '0; bit_d = BIT_W'(ROOT_W - 1); total_d = '0;
      end
      OP_SQRT: begin
        if (sq <= SQ_W'(x_q)) begin
          root_d = trial;
        end
        bit_d = bit_q - 1'b1;
      end
      OP_DIV_XS: div_start = 1'b1;
      OP_SETUP: begin
        cnt_d = (quot == X_W'(root_q)) ? CNT_W'({root_q, 1'b0} - 1'b1)
                                       : CNT_W'({root_q, 1'b0});
        v_d = X_W'(1); phb_d = 1'b0; i_d = root_q;
      end
      OP_EVSTART: begin
        total_d = TOT_W'(1); k_d = X_W'(2);
      end
      OP_DIV_VK: begin
        div_start = 1'b1; div_a = v_q; div_b = k_q;
      end
      OP_QCAP: q_d = quot;
      OP_DIV_VQ: begin
        div_start = 1'b1; div_a = v_q; div_b = q_q;
      end
      OP_NKCAP: nk_d = quot + 1'b1;
      OP_RD_SMALL: begin
        ram_re = 1'b1; ram_addr = ADDR_W'(q_q - 1'b1);
      end
      OP_DIV_XQ: begin
        div_start = 1'b1; div_b = q_q;
      end
      OP_RD_LARGE: begin
        ram_re = 1'b1; ram_addr = large_addr[ADDR_W-1:0];
      end
      OP_MUL: prod_d = prod_w[TOT_W-1:0];
      OP_ACC: begin
        total_d = total_q - prod_q; k_d = nk_q;
      end
      OP_WR_SMALL: begin
        ram_we = 1'b1; ram_addr = ADDR_W'(v_q - 1'b1);
      end
      OP_DIV_XV: begin
        div_start = 1'b1; div_b = v_q;
      end
      OP_WR_LARGE: begin
        ram_we = 1'b1; ram_addr = large_addr[ADDR_W-1:0];
      end
      OP_VINC: v_d = v_q + 1'b1;
      OP_PHB: begin
        phb_d = 1'b1; i_d = root_q;
      end
      OP_IDEC: i_d = i_q - 1'b1;
      OP_DIV_XI: begin
        div_start = 1'b1; div_b = X_W'(i_q);
      end
      OP_BCAP: v_d = quot;
      OP_FINISH: begin
        ov_d  = 1'b1;
        err_d = ({1'b0, x_q} > LIMIT);
        if (total_q > OUT_MAX) begin
          val_d = OUT_MAX[VAL_W-1:0];
        end else if (total_q < OUT_MIN) begin
          val_d = OUT_MIN[VAL_W-1:0];
        end else begin
          val_d = total_q[VAL_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d; v_q <= v_d; k_q <= k_d; q_q <= q_d; nk_q <= nk_d;
    root_q <= root_d; i_q <= i_d; bit_q <= bit_d; cnt_q <= cnt_d;
    total_q <= total_d; prod_q <= prod_d; phb_q <= phb_d;
    err_q <= err_d; val_q <= val_d;
  end

  assign stat_o.over      = {1'b0, x_q} > LIMIT;
  assign stat_o.zero      = (x_q == '0);
  assign stat_o.sqrt_last = (bit_q == '0);
  assign stat_o.div_done  = div_done;
  assign stat_o.k_le_v    = (k_q <= v_q);
  assign stat_o.q_le_s    = (q_q <= X_W'(root_q));
  assign stat_o.v_le_s    = (v_q <= X_W'(root_q));
  assign stat_o.v_lt_s    = (v_q < X_W'(root_q));
  assign stat_o.phase_b   = phb_q;
  assign stat_o.i_one     = (i_q == ROOT_W'(1));
  assign stat_o.out_free  = !ov_q || out_ready_i;

  assign out_valid_o     = ov_q;
  assign mertens_value_o = val_q;
  assign range_error_o   = err_q;

endmodule

// ===== hdl/mfh_ctrl.sv =====
// ----------------------------------------------------------------------------
// mfh_ctrl
// Sequencer: square root, ascending walk over the distinct quotients and
// the block sum for each of them.
// ----------------------------------------------------------------------------
module mfh_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mfh_pkg::mfh_stat_t stat_i,
  output mfh_pkg::mfh_cmd_t  cmd_o
);
  import mfh_pkg::*;

  typedef enum logic [20:0] {
    ST_IDLE    = 21'h000001,
    ST_CHECK   = 21'h000002,
    ST_SQRT    = 21'h000004,
    ST_DUPDIV  = 21'h000008,
    ST_DUPWAIT = 21'h000010,
    ST_EVSTART = 21'h000020,
    ST_KCHK    = 21'h000040,
    ST_QDIV    = 21'h000080,
    ST_QWAIT   = 21'h000100,
    ST_NKDIV   = 21'h000200,
    ST_NKWAIT  = 21'h000400,
    ST_ADDR    = 21'h000800,
    ST_AWAIT   = 21'h001000,
    ST_MUL     = 21'h002000,
    ST_ACC     = 21'h004000,
    ST_WADDR   = 21'h008000,
    ST_WWAIT   = 21'h010000,
    ST_NEXTV   = 21'h020000,
    ST_BWAIT   = 21'h040000,
    ST_BCHK    = 21'h080000,
    ST_FINISH  = 21'h100000
  } mfh_state_e;

  mfh_state_e state_q, state_d;
  mfh_op_e    op;

  always_comb begin
    state_d = state_q;
    op      = OP_NONE;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op = OP_LOAD; state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat_i.over || stat_i.zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_SQRT;
        end
      end
      ST_SQRT: begin
        op = OP_SQRT;
        if (stat_i.sqrt_last) begin
          state_d = ST_DUPDIV;
        end
      end
      ST_DUPDIV: begin
        op = OP_DIV_XS; state_d = ST_DUPWAIT;
      end
      ST_DUPWAIT: begin
        if (stat_i.div_done) begin
          op = OP_SETUP; state_d = ST_EVSTART;
        end
      end
      ST_EVSTART: begin
        if (stat_i.phase_b && stat_i.v_le_s) begin
          // Quotients at or below the root were already evaluated in the small walk.
          state_d = ST_NEXTV;
        end else begin
          op = OP_EVSTART; state_d = ST_KCHK;
        end
      end
      ST_KCHK: state_d = stat_i.k_le_v ? ST_QDIV : ST_WADDR;
      ST_QDIV: begin
        op = OP_DIV_VK; state_d = ST_QWAIT;
      end
      ST_QWAIT: begin
        if (stat_i.div_done) begin
          op = OP_QCAP; state_d = ST_NKDIV;
        end
      end
      ST_NKDIV: begin
        op = OP_DIV_VQ; state_d = ST_NKWAIT;
      end
      ST_NKWAIT: begin
        if (stat_i.div_done) begin
          op = OP_NKCAP; state_d = ST_ADDR;
        end
      end
      ST_ADDR: begin
        if (stat_i.q_le_s) begin
          op = OP_RD_SMALL; state_d = ST_MUL;
        end else begin
          op = OP_DIV_XQ; state_d = ST_AWAIT;
        end
      end
      ST_AWAIT: begin
        if (stat_i.div_done) begin
          op = OP_RD_LARGE; state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        op = OP_MUL; state_d = ST_ACC;
      end
      ST_ACC: begin
        op = OP_ACC; state_d = ST_KCHK;
      end
      ST_WADDR: begin
        if (stat_i.v_le_s) begin
          op = OP_WR_SMALL; state_d = ST_NEXTV;
        end else begin
          op = OP_DIV_XV; state_d = ST_WWAIT;
        end
      end
      ST_WWAIT: begin
        if (stat_i.div_done) begin
          op = OP_WR_LARGE; state_d = ST_NEXTV;
        end
      end
      ST_NEXTV: begin
        if (!stat_i.phase_b) begin
          if (stat_i.v_lt_s) begin
            op = OP_VINC; state_d = ST_EVSTART;
          end else begin
            // Small values are done; start the large ones at i = s.
            op = OP_PHB; state_d = ST_BWAIT;
          end
        end else if (stat_i.i_one) begin
          state_d = ST_FINISH;
        end else begin
          op = OP_IDEC; state_d = ST_BWAIT;
        end
      end
      ST_BWAIT: begin
        op = OP_DIV_XI; state_d = ST_BCHK;
      end
      ST_BCHK: begin
        if (stat_i.div_done) begin
          op = OP_BCAP; state_d = ST_EVSTART;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          op = OP_FINISH; state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign cmd_o.op   = op;

endmodule

// ===== hdl/mertens_function_hyperbola.sv =====
// Cost: two or three divides per block of k and one more per stored large
// value, about x^(3/4) blocks per query; for x = 0 or an out-of-range x the controller
// skips the walk and goes from its check state straight to the finish state.
// One bound is in flight at a time; the shared one-bit-per-cycle divider sets the rate.
// The result register frees the input side while a result waits.
// Reset is asynchronous and active low; the partial result table needs no clearing.
// ----------------------------------------------------------------------------
// mertens_function_hyperbola
// Computes the Mertens function M(x) with the hyperbola recurrence over the
// distinct quotients of x, one query at a time.
// ----------------------------------------------------------------------------
module mertens_function_hyperbola (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [mfh_pkg::X_W-1:0]           bound_x_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [mfh_pkg::VAL_W-1:0]  mertens_value_o,
  output logic                              range_error_o
);
  import mfh_pkg::*;

  mfh_cmd_t  cmd;
  mfh_stat_t stat;

  mfh_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mfh_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .bound_x_i       (bound_x_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .mertens_value_o (mertens_value_o),
    .range_error_o   (range_error_o)
  );

endmodule
